FILE: rtl/tlr_pkg.sv
// shared constants, codes and control structs for the thick line rasterizer
package tlr_pkg;

    // default build constants
    localparam int MAX_RADIUS_DEF = 63;
    localparam int COORD_BITS_DEF = 16;

    // fixed field widths
    localparam int IN_COORD_W  = 16;
    localparam int IN_RAD_W    = 6;
    localparam int COLOR_W     = 32;
    localparam int PIX_W       = 17;
    localparam int CANVAS_BITS = 15;
    localparam int S_TDATA_W   = 104;
    localparam int M_TDATA_W   = 72;
    localparam int CFG_IDX_W   = 1;

    // input beat kinds carried on s_tuser
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT = 1'b1;

    // canvas size after reset
    localparam logic [CANVAS_BITS-1:0] CANVAS_WIDTH_RST  = 15'd640;
    localparam logic [CANVAS_BITS-1:0] CANVAS_HEIGHT_RST = 15'd480;

    // commands from the top level to the walker
    typedef struct packed {
        logic load;
        logic step;
    } tlr_ctrl_t;

    // walker status back to the top level
    typedef struct packed {
        logic busy;
        logic last;
    } tlr_stat_t;

endpackage

FILE: rtl/tlr_walker.sv
// bresenham walker with the brush square scan, one candidate per step beat
module tlr_walker #(
    parameter int MAX_RADIUS = tlr_pkg::MAX_RADIUS_DEF,
    parameter int COORD_BITS = tlr_pkg::COORD_BITS_DEF,
    parameter int RAD_W      = 6,
    parameter int OFS_W      = 7
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  tlr_pkg::tlr_ctrl_t                     ctrl,
    input  logic signed [tlr_pkg::IN_COORD_W-1:0]  start_x,
    input  logic signed [tlr_pkg::IN_COORD_W-1:0]  start_y,
    input  logic signed [tlr_pkg::IN_COORD_W-1:0]  end_x,
    input  logic signed [tlr_pkg::IN_COORD_W-1:0]  end_y,
    input  logic [tlr_pkg::IN_RAD_W-1:0]           brush_radius,
    input  logic [tlr_pkg::COLOR_W-1:0]            color,
    output logic signed [COORD_BITS-1:0]           cur_x,
    output logic signed [COORD_BITS-1:0]           cur_y,
    output logic signed [OFS_W-1:0]                ofs_x,
    output logic signed [OFS_W-1:0]                ofs_y,
    output logic [2*RAD_W-1:0]                     rad_sq,
    output logic [tlr_pkg::COLOR_W-1:0]            color_held,
    output tlr_pkg::tlr_stat_t                     stat
);

    localparam int SPAN_W = COORD_BITS + 1;
    localparam int ERR_W  = COORD_BITS + 3;

    logic signed [COORD_BITS-1:0] cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic signed [COORD_BITS-1:0] tgt_x_reg, tgt_x_next, tgt_y_reg, tgt_y_next;
    logic [SPAN_W-1:0]            span_x_reg, span_x_next, span_y_reg, span_y_next;
    logic                         neg_x_reg, neg_x_next, neg_y_reg, neg_y_next;
    logic signed [ERR_W-1:0]      err_reg, err_next;
    logic signed [OFS_W-1:0]      ofs_x_reg, ofs_x_next, ofs_y_reg, ofs_y_next;
    logic [RAD_W-1:0]             rad_reg, rad_next;
    logic [2*RAD_W-1:0]           rad_sq_reg, rad_sq_next;
    logic [tlr_pkg::COLOR_W-1:0]  color_reg, color_next;
    logic                         busy_reg, busy_next;

    logic signed [COORD_BITS-1:0] x0, y0, x1, y1;
    logic [7:0]                   rad_ext, rad_sat;
    logic [RAD_W-1:0]             rad_in;
    logic signed [OFS_W-1:0]      rad_s, rad_in_s;
    logic signed [ERR_W:0]        e2, neg_sy, sx_s;
    logic                         at_end, x_wrap, y_wrap;

    // endpoints in the working coordinate width
    assign x0 = COORD_BITS'(start_x);
    assign y0 = COORD_BITS'(start_y);
    assign x1 = COORD_BITS'(end_x);
    assign y1 = COORD_BITS'(end_y);

    // radius clamp
    assign rad_ext  = 8'(brush_radius);
    assign rad_sat  = (rad_ext > 8'(MAX_RADIUS)) ? 8'(MAX_RADIUS) : rad_ext;
    assign rad_in   = rad_sat[RAD_W-1:0];
    assign rad_in_s = $signed({1'b0, rad_in});
    assign rad_s    = $signed({1'b0, rad_reg});

    // scan position tests
    assign at_end = (cur_x_reg == tgt_x_reg) && (cur_y_reg == tgt_y_reg);
    assign x_wrap = (ofs_x_reg == rad_s);
    assign y_wrap = (ofs_y_reg == rad_s);

    // bresenham decision terms
    assign e2     = $signed({err_reg, 1'b0});
    assign neg_sy = -$signed({1'b0, ERR_W'(span_y_reg)});
    assign sx_s   = $signed({1'b0, ERR_W'(span_x_reg)});

    // next state
    always_comb begin
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        tgt_x_next  = tgt_x_reg;
        tgt_y_next  = tgt_y_reg;
        span_x_next = span_x_reg;
        span_y_next = span_y_reg;
        neg_x_next  = neg_x_reg;
        neg_y_next  = neg_y_reg;
        err_next    = err_reg;
        ofs_x_next  = ofs_x_reg;
        ofs_y_next  = ofs_y_reg;
        rad_next    = rad_reg;
        rad_sq_next = rad_sq_reg;
        color_next  = color_reg;
        busy_next   = busy_reg;
        if (ctrl.load) begin
            cur_x_next  = x0;
            cur_y_next  = y0;
            tgt_x_next  = x1;
            tgt_y_next  = y1;
            span_x_next = (x1 > x0) ? SPAN_W'(x1) - SPAN_W'(x0) : SPAN_W'(x0) - SPAN_W'(x1);
            span_y_next = (y1 > y0) ? SPAN_W'(y1) - SPAN_W'(y0) : SPAN_W'(y0) - SPAN_W'(y1);
            neg_x_next  = !(x0 < x1);
            neg_y_next  = !(y0 < y1);
            err_next    = $signed(ERR_W'(span_x_next)) - $signed(ERR_W'(span_y_next));
            rad_next    = rad_in;
            rad_sq_next = (2*RAD_W)'(rad_in) * (2*RAD_W)'(rad_in);
            ofs_x_next  = -rad_in_s;
            ofs_y_next  = -rad_in_s;
            color_next  = color;
            busy_next   = 1'b1;
        end else if (ctrl.step && busy_reg) begin
            if (!x_wrap) begin
                ofs_x_next = ofs_x_reg + OFS_W'(1);
            end else begin
                ofs_x_next = -rad_s;
                if (!y_wrap) begin
                    ofs_y_next = ofs_y_reg + OFS_W'(1);
                end else begin
                    ofs_y_next = -rad_s;
                    if (at_end) begin
                        busy_next = 1'b0;
                    end else begin
                        if (e2 > neg_sy) begin
                            cur_x_next = neg_x_reg ? cur_x_reg - COORD_BITS'(1)
                                                   : cur_x_reg + COORD_BITS'(1);
                        end
                        if (e2 < sx_s) begin
                            cur_y_next = neg_y_reg ? cur_y_reg - COORD_BITS'(1)
                                                   : cur_y_reg + COORD_BITS'(1);
                        end
                        err_next = err_reg
                                 - ((e2 > neg_sy) ? $signed(ERR_W'(span_y_reg)) : '0)
                                 + ((e2 < sx_s)   ? $signed(ERR_W'(span_x_reg)) : '0);
                    end
                end
            end
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        cur_x_reg  <= cur_x_next;
        cur_y_reg  <= cur_y_next;
        tgt_x_reg  <= tgt_x_next;
        tgt_y_reg  <= tgt_y_next;
        span_x_reg <= span_x_next;
        span_y_reg <= span_y_next;
        neg_x_reg  <= neg_x_next;
        neg_y_reg  <= neg_y_next;
        err_reg    <= err_next;
        ofs_x_reg  <= ofs_x_next;
        ofs_y_reg  <= ofs_y_next;
        rad_reg    <= rad_next;
        rad_sq_reg <= rad_sq_next;
        color_reg  <= color_next;
    end

    assign cur_x      = cur_x_reg;
    assign cur_y      = cur_y_reg;
    assign ofs_x      = ofs_x_reg;
    assign ofs_y      = ofs_y_reg;
    assign rad_sq     = rad_sq_reg;
    assign color_held = color_reg;
    assign stat.busy  = busy_reg;
    assign stat.last  = at_end && x_wrap && y_wrap;

endmodule

FILE: rtl/tlr_pixel.sv
// candidate pixel position, disc test and canvas clip
module tlr_pixel #(
    parameter int COORD_BITS = tlr_pkg::COORD_BITS_DEF,
    parameter int RAD_W      = 6,
    parameter int OFS_W      = 7
) (
    input  logic signed [COORD_BITS-1:0]          cur_x,
    input  logic signed [COORD_BITS-1:0]          cur_y,
    input  logic signed [OFS_W-1:0]               ofs_x,
    input  logic signed [OFS_W-1:0]               ofs_y,
    input  logic [2*RAD_W-1:0]                    rad_sq,
    input  logic [tlr_pkg::CANVAS_BITS-1:0]       canvas_width,
    input  logic [tlr_pkg::CANVAS_BITS-1:0]       canvas_height,
    output logic signed [tlr_pkg::PIX_W-1:0]      pixel_x,
    output logic signed [tlr_pkg::PIX_W-1:0]      pixel_y,
    output logic                                  write_enable
);

    localparam int SUM_W = ((COORD_BITS > OFS_W) ? COORD_BITS : OFS_W) + 1;
    localparam int CMP_W = ((SUM_W > tlr_pkg::CANVAS_BITS) ? SUM_W : tlr_pkg::CANVAS_BITS) + 1;
    localparam int SQ_W  = 2*OFS_W + 1;

    logic signed [SUM_W-1:0]    px, py;
    logic signed [CMP_W-1:0]    px_c, py_c, w_c, h_c;
    logic signed [2*OFS_W-1:0]  sq_x, sq_y;
    logic [SQ_W-1:0]            dist_sq;
    logic                       in_disc, on_canvas;

    // pixel position
    assign px = SUM_W'(cur_x) + SUM_W'(ofs_x);
    assign py = SUM_W'(cur_y) + SUM_W'(ofs_y);
    assign pixel_x = tlr_pkg::PIX_W'(px);
    assign pixel_y = tlr_pkg::PIX_W'(py);

    // disc membership
    assign sq_x    = ofs_x * ofs_x;
    assign sq_y    = ofs_y * ofs_y;
    assign dist_sq = SQ_W'($unsigned(sq_x)) + SQ_W'($unsigned(sq_y));
    assign in_disc = dist_sq <= SQ_W'(rad_sq);

    // canvas clip
    assign px_c = CMP_W'(px);
    assign py_c = CMP_W'(py);
    assign w_c  = $signed(CMP_W'(canvas_width));
    assign h_c  = $signed(CMP_W'(canvas_height));
    assign on_canvas = (px_c >= 0) && (py_c >= 0) && (px_c < w_c) && (py_c < h_c);

    assign write_enable = in_disc && on_canvas;

endmodule

FILE: rtl/thick_line_rasterizer_top.sv
// top level of the thick line rasterizer: ports, canvas registers, output register
//
// Draws a line with a round brush, one candidate pixel per step beat.
// Input channel s_*: s_tuser selects the beat kind. A start beat loads both
// endpoints, the brush radius (clamped to MAX_RADIUS) and the color and gives
// no output. A step beat while a line is active gives one candidate pixel;
// a step beat while idle is consumed and gives nothing. A start beat while a
// line is active drops that line.
// Output channel m_*: pixel position and color in m_tdata, the write flag in
// m_tuser (disc test and canvas clip), m_tlast on the final candidate.
// Candidates come row by row over the brush square at each Bresenham point.
// m_tvalid rises in the cycle after the accepted step beat.
// Throughput: one beat per cycle while m_tready is high; the candidate goes
// combinationally from the walker state into the output register.
// A stalled receiver holds the output register; s_tready stays high while
// the output register is empty or being taken in the same cycle.
// Reset (aresetn low, synchronous) leaves the block idle with an empty output
// and the canvas at 640 x 480; no clearing pass is needed. Canvas size is set
// with cfg_we / cfg_index / cfg_data, by the user only while idle; not enforced.
module thick_line_rasterizer_top #(
    parameter int MAX_RADIUS = tlr_pkg::MAX_RADIUS_DEF,
    parameter int COORD_BITS = tlr_pkg::COORD_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input channel
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // start_x, start_y, end_x, end_y, brush_radius, color, zero pad
    input  logic [tlr_pkg::S_TDATA_W-1:0]     s_tdata,
    // cmd
    input  logic                              s_tuser,
    // result channel
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // pixel_x, pixel_y, pixel_color, zero pad
    output logic [tlr_pkg::M_TDATA_W-1:0]     m_tdata,
    // write_enable
    output logic                              m_tuser,
    output logic                              m_tlast,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [tlr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tlr_pkg::CANVAS_BITS-1:0]   cfg_data
);

    localparam int RAD_W = (MAX_RADIUS > 0) ? $clog2(MAX_RADIUS + 1) : 1;
    localparam int OFS_W = RAD_W + 1;

    logic [tlr_pkg::CANVAS_BITS-1:0] width_reg, height_reg;
    logic                           m_valid_reg, m_valid_next;
    logic [tlr_pkg::PIX_W-1:0]      px_reg, py_reg;
    logic [tlr_pkg::COLOR_W-1:0]    color_out_reg;
    logic                           we_reg, last_reg;

    logic                           accept;
    tlr_pkg::tlr_ctrl_t             ctrl;
    tlr_pkg::tlr_stat_t             stat;
    logic signed [COORD_BITS-1:0]   cur_x, cur_y;
    logic signed [OFS_W-1:0]        ofs_x, ofs_y;
    logic [2*RAD_W-1:0]             rad_sq;
    logic [tlr_pkg::COLOR_W-1:0]    color_held;
    logic signed [tlr_pkg::PIX_W-1:0] pixel_x, pixel_y;
    logic                           write_enable;
    logic                           res_valid;

    // input handshake
    assign s_tready  = !m_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign ctrl.load = accept && (s_tuser == tlr_pkg::CMD_START);
    assign ctrl.step = accept && (s_tuser == tlr_pkg::CMD_STEP);
    assign res_valid = ctrl.step && stat.busy;

    tlr_walker #(
        .MAX_RADIUS (MAX_RADIUS),
        .COORD_BITS (COORD_BITS),
        .RAD_W      (RAD_W),
        .OFS_W      (OFS_W)
    ) u_walker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctrl         (ctrl),
        .start_x      (s_tdata[15:0]),
        .start_y      (s_tdata[31:16]),
        .end_x        (s_tdata[47:32]),
        .end_y        (s_tdata[63:48]),
        .brush_radius (s_tdata[69:64]),
        .color        (s_tdata[101:70]),
        .cur_x        (cur_x),
        .cur_y        (cur_y),
        .ofs_x        (ofs_x),
        .ofs_y        (ofs_y),
        .rad_sq       (rad_sq),
        .color_held   (color_held),
        .stat         (stat)
    );

    tlr_pixel #(
        .COORD_BITS (COORD_BITS),
        .RAD_W      (RAD_W),
        .OFS_W      (OFS_W)
    ) u_pixel (
        .cur_x         (cur_x),
        .cur_y         (cur_y),
        .ofs_x         (ofs_x),
        .ofs_y         (ofs_y),
        .rad_sq        (rad_sq),
        .canvas_width  (width_reg),
        .canvas_height (height_reg),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .write_enable  (write_enable)
    );

    // canvas size registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= tlr_pkg::CANVAS_WIDTH_RST;
            height_reg <= tlr_pkg::CANVAS_HEIGHT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                tlr_pkg::REG_CANVAS_WIDTH:  width_reg  <= cfg_data;
                tlr_pkg::REG_CANVAS_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // output valid
    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = res_valid;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (res_valid) begin
            px_reg        <= pixel_x;
            py_reg        <= pixel_y;
            color_out_reg <= color_held;
            we_reg        <= write_enable;
            last_reg      <= stat.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, color_out_reg, py_reg, px_reg};
    assign m_tuser  = we_reg;
    assign m_tlast  = last_reg;

endmodule
